[src/http2_frame_deframer_top_macros.svh]
//------------------------------------------------------------------------------
// HTTP/2 frame deframer assertion macros
// Shared assertion forms for the deframer RTL.
//------------------------------------------------------------------------------
`ifndef HTTP2_FRAME_DEFRAMER_TOP_MACROS_SVH
`define HTTP2_FRAME_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication
`define HFD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HFD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/http2fd_pkg.sv]
//------------------------------------------------------------------------------
// HTTP/2 frame deframer package
// Types, codes and constants shared by the deframer modules.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package http2fd_pkg;

    localparam int unsigned LEN_W       = 24;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SID_W       = 31;
    localparam int unsigned HDR_BYTES   = 9;
    localparam int unsigned PADDED_BIT  = 3;

    localparam logic [7:0] TYPE_DATA         = 8'd0;
    localparam logic [7:0] TYPE_PRIORITY     = 8'd2;
    localparam logic [7:0] TYPE_PUSH_PROMISE = 8'd5;
    localparam logic [7:0] TYPE_PING         = 8'd6;
    localparam logic [7:0] TYPE_GOAWAY       = 8'd7;
    localparam logic [7:0] TYPE_CONTINUATION = 8'd9;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PADLEN,
        PH_DATA,
        PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_PAD_ERR,
        ST_UNIMPL,
        ST_INVALID
    } status_t;

    typedef enum logic {
        KIND_HEADER,
        KIND_DATA
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [LEN_W-1:0]   frame_length;
        logic [BYTE_W-1:0]  frame_type;
        logic [BYTE_W-1:0]  frame_flags;
        logic               reserved_bit;
        logic [SID_W-1:0]   stream_id;
        logic [BYTE_W-1:0]  pad_length;
        logic [BYTE_W-1:0]  payload_byte;
        logic               last_of_frame;
        status_t            status;
    } result_t;

endpackage

[src/http2fd_in_reg.sv]
//------------------------------------------------------------------------------
// HTTP/2 deframer input register
// Holds one received byte until the parser steps on it.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module http2fd_in_reg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  data_byte,
    input  logic                        step_free,
    output logic                        held_valid,
    output logic [7:0]                  held_byte
);
    import http2fd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              take;

    assign in_stall   = valid_reg && !step_free;
    assign take       = in_valid && !in_stall;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (step_free)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            byte_reg <= data_byte;
    end

endmodule

[src/http2fd_parser.sv]
//------------------------------------------------------------------------------
// HTTP/2 deframer parser
// Frame state and the per-byte step: header collection, pad length, data, skip.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module http2fd_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step_en,
    input  logic [7:0]                  b,
    output logic                        res_valid,
    output http2fd_pkg::result_t        res
);
    import http2fd_pkg::*;
    `include "http2_frame_deframer_top_macros.svh"

    phase_t            phase_reg, phase_next;
    logic [3:0]        header_count_reg, header_count_next;
    logic [LEN_W-1:0]  held_length_reg, held_length_next;
    logic [7:0]        held_type_reg, held_type_next;
    logic [7:0]        held_flags_reg, held_flags_next;
    logic [31:0]       held_stream_reg, held_stream_next;
    logic [7:0]        held_pad_reg, held_pad_next;
    logic [LEN_W-1:0]  data_left_reg, data_left_next;
    logic [LEN_W-1:0]  skip_left_reg, skip_left_next;

    logic [3:0]        cnt;
    logic              hdr_last;
    logic [LEN_W-1:0]  len_hdr;
    logic [31:0]       stream_hdr;
    logic [7:0]        type_hdr;
    logic [7:0]        flags_hdr;
    logic              is_data;
    logic              padded;
    logic              len_zero;
    logic              unimpl;
    logic              invalid;
    logic [LEN_W-1:0]  b_ext;
    logic              pad_big;
    logic [LEN_W-1:0]  len_m1;
    logic [LEN_W-1:0]  data_after_pad;
    logic [LEN_W-1:0]  data_dec;
    logic [LEN_W-1:0]  skip_dec;

    assign cnt      = (header_count_reg > 4'(HDR_BYTES - 1)) ? 4'd0 : header_count_reg;
    assign hdr_last = (cnt == 4'(HDR_BYTES - 1));

    assign len_hdr    = (cnt == 4'd0) ? {16'd0, b} :
                        (cnt < 4'd3)  ? {held_length_reg[15:0], b} : held_length_reg;
    assign type_hdr   = (cnt == 4'd3) ? b : held_type_reg;
    assign flags_hdr  = (cnt == 4'd4) ? b : held_flags_reg;
    assign stream_hdr = (cnt == 4'd0) ? 32'd0 :
                        (cnt >= 4'd5) ? {held_stream_reg[23:0], b} : held_stream_reg;

    assign is_data  = (type_hdr == TYPE_DATA);
    assign padded   = flags_hdr[PADDED_BIT];
    assign len_zero = (len_hdr == '0);
    assign unimpl   = (type_hdr == TYPE_PRIORITY) || (type_hdr == TYPE_PUSH_PROMISE) ||
                      (type_hdr == TYPE_PING) || (type_hdr == TYPE_GOAWAY) ||
                      (type_hdr == TYPE_CONTINUATION);
    assign invalid  = (type_hdr > TYPE_CONTINUATION);

    assign b_ext          = {16'd0, b};
    assign pad_big        = (b_ext >= held_length_reg);
    assign len_m1         = held_length_reg - 24'd1;
    assign data_after_pad = len_m1 - b_ext;
    assign data_dec       = data_left_reg - 24'd1;
    assign skip_dec       = skip_left_reg - 24'd1;

    // datapath next values
    always_comb
    begin
        header_count_next = header_count_reg;
        held_length_next  = held_length_reg;
        held_type_next    = held_type_reg;
        held_flags_next   = held_flags_reg;
        held_stream_next  = held_stream_reg;
        held_pad_next     = held_pad_reg;
        data_left_next    = data_left_reg;
        skip_left_next    = skip_left_reg;
        if (step_en)
        begin
            unique case (phase_reg)
                PH_PADLEN:
                begin
                    held_pad_next = b;
                    if (pad_big)
                    begin
                        data_left_next = '0;
                        skip_left_next = len_m1;
                    end
                    else
                    begin
                        data_left_next = data_after_pad;
                        skip_left_next = b_ext;
                    end
                end
                PH_DATA:
                    data_left_next = data_dec;
                PH_SKIP:
                    skip_left_next = skip_dec;
                PH_HEADER:
                begin
                    held_length_next  = len_hdr;
                    held_type_next    = type_hdr;
                    held_flags_next   = flags_hdr;
                    held_stream_next  = stream_hdr;
                    header_count_next = hdr_last ? 4'd0 : cnt + 4'd1;
                    if (hdr_last)
                    begin
                        held_pad_next  = '0;
                        data_left_next = (is_data && !padded) ? len_hdr : '0;
                        skip_left_next = is_data ? '0 : len_hdr;
                    end
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (step_en)
        begin
            if (phase_reg == PH_HEADER && !hdr_last)
                phase_next = PH_HEADER;
            else if (phase_reg == PH_HEADER && is_data && padded && !len_zero)
                phase_next = PH_PADLEN;
            else if (data_left_next != '0)
                phase_next = PH_DATA;
            else if (skip_left_next != '0)
                phase_next = PH_SKIP;
            else
                phase_next = PH_HEADER;
        end
    end

    // result
    always_comb
    begin
        res_valid         = 1'b0;
        res.kind          = KIND_HEADER;
        res.frame_length  = held_length_next;
        res.frame_type    = held_type_next;
        res.frame_flags   = held_flags_next;
        res.reserved_bit  = held_stream_next[31];
        res.stream_id     = held_stream_next[SID_W-1:0];
        res.pad_length    = held_pad_next;
        res.payload_byte  = '0;
        res.last_of_frame = 1'b1;
        res.status        = ST_OK;
        unique case (phase_reg)
            PH_PADLEN:
            begin
                res_valid         = step_en;
                res.last_of_frame = pad_big || (data_after_pad == '0);
                res.status        = pad_big ? ST_PAD_ERR : ST_OK;
            end
            PH_DATA:
            begin
                res_valid         = step_en;
                res.kind          = KIND_DATA;
                res.payload_byte  = b;
                res.last_of_frame = (data_dec == '0);
            end
            PH_SKIP:
                res_valid = 1'b0;
            PH_HEADER:
            begin
                res_valid = step_en && hdr_last && !(is_data && padded && !len_zero);
                priority if (is_data && padded)
                    res.status = ST_PAD_ERR;
                else if (is_data)
                begin
                    res.status        = ST_OK;
                    res.last_of_frame = len_zero;
                end
                else if (unimpl)
                    res.status = ST_UNIMPL;
                else if (invalid)
                    res.status = ST_INVALID;
                else
                    res.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            header_count_reg <= '0;
            held_length_reg  <= '0;
            held_type_reg    <= '0;
            held_flags_reg   <= '0;
            held_stream_reg  <= '0;
            held_pad_reg     <= '0;
            data_left_reg    <= '0;
            skip_left_reg    <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            held_length_reg  <= held_length_next;
            held_type_reg    <= held_type_next;
            held_flags_reg   <= held_flags_next;
            held_stream_reg  <= held_stream_next;
            held_pad_reg     <= held_pad_next;
            data_left_reg    <= data_left_next;
            skip_left_reg    <= skip_left_next;
        end
    end

    `HFD_ASSERT_IMP(a_data_nonzero, clk, rst_n, phase_reg == PH_DATA, data_left_reg != '0, "data phase with no data left")
    `HFD_ASSERT_IMP(a_skip_nonzero, clk, rst_n, phase_reg == PH_SKIP, skip_left_reg != '0, "skip phase with nothing to skip")
    `HFD_ASSERT_IMP(a_padlen_len, clk, rst_n, phase_reg == PH_PADLEN, held_length_reg != '0, "pad length byte on empty frame")
    `HFD_ASSERT_NXT(a_cnt_outside_hdr, clk, rst_n, phase_reg != PH_HEADER, header_count_reg == 4'd0, "header count left nonzero")

endmodule

[src/http2fd_out_reg.sv]
//------------------------------------------------------------------------------
// HTTP/2 deframer output register
// Holds one result item until the downstream side takes it.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module http2fd_out_reg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  http2fd_pkg::result_t        res,
    output logic                        free,
    output logic                        out_valid,
    input  logic                        out_stall,
    output http2fd_pkg::result_t        out_res
);
    import http2fd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (free)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

endmodule

[src/http2_frame_deframer_top.sv]
//------------------------------------------------------------------------------
// HTTP/2 frame deframer
// Splits a received HTTP/2 byte stream into header reports and DATA bytes.
//
//   channel | direction | signals
//   --------+-----------+-------------------------------------------------
//   in      | sink      | in_valid, in_stall, data_byte
//   out     | source    | out_valid, out_stall, kind .. status
//
// One byte item per clock sustained while the output is not stalled; a byte is
// taken into the input register when accepted, and its parser step then loads
// its result into the output register.
// Reset clears the frame state and the valid flags of both registers; no clearing pass.
// out_stall holds the output register and, once the input register is full,
// raises in_stall in the same cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module http2_frame_deframer_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   data_byte,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         kind,
    output logic [23:0]  frame_length,
    output logic [7:0]   frame_type,
    output logic [7:0]   frame_flags,
    output logic         reserved_bit,
    output logic [30:0]  stream_id,
    output logic [7:0]   pad_length,
    output logic [7:0]   payload_byte,
    output logic         last_of_frame,
    output logic [1:0]   status
);
    import http2fd_pkg::*;

    logic              step_free;
    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    logic              step_en;
    logic              res_valid;
    result_t           res;
    result_t           out_res;

    assign step_en = held_valid && step_free;

    http2fd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .step_free  (step_free),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    http2fd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .b         (held_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    http2fd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .free      (step_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign kind          = out_res.kind;
    assign frame_length  = out_res.frame_length;
    assign frame_type    = out_res.frame_type;
    assign frame_flags   = out_res.frame_flags;
    assign reserved_bit  = out_res.reserved_bit;
    assign stream_id     = out_res.stream_id;
    assign pad_length    = out_res.pad_length;
    assign payload_byte  = out_res.payload_byte;
    assign last_of_frame = out_res.last_of_frame;
    assign status        = out_res.status;

endmodule

[verif/testbench.sv]
//------------------------------------------------------------------------------
// HTTP/2 frame deframer testbench
// Feeds the deframer a byte stream of HTTP/2 frames and checks every header
// report and forwarded DATA byte against a cycle-free model of the parser.
// A short table of hand-built frames opens the run: a zero-length header of an
// invalid type with all-ones type, flags and stream, a zero-length padded DATA
// frame, and an oversized pad length. Then random frames, mostly well formed,
// under two sender/receiver idle mixes, back-to-back frames with a long output
// hold that backs up the input, and a maximum-length header at the very end.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import http2fd_pkg::*;

    localparam logic [7:0] TYPE_HEADERS       = 8'd1;
    localparam logic [7:0] TYPE_RST_STREAM    = 8'd3;
    localparam logic [7:0] TYPE_SETTINGS      = 8'd4;
    localparam logic [7:0] TYPE_WINDOW_UPDATE = 8'd8;

    localparam int DIRECTED_LEN = 29;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 3000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         in_valid = 1'b0;
    logic         in_stall;
    logic [7:0]   data_byte = 8'd0;
    logic         out_valid;
    logic         out_stall = 1'b0;
    logic         kind;
    logic [23:0]  frame_length;
    logic [7:0]   frame_type;
    logic [7:0]   frame_flags;
    logic         reserved_bit;
    logic [30:0]  stream_id;
    logic [7:0]   pad_length;
    logic [7:0]   payload_byte;
    logic         last_of_frame;
    logic [1:0]   status;

    http2_frame_deframer_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .frame_length  (frame_length),
        .frame_type    (frame_type),
        .frame_flags   (frame_flags),
        .reserved_bit  (reserved_bit),
        .stream_id     (stream_id),
        .pad_length    (pad_length),
        .payload_byte  (payload_byte),
        .last_of_frame (last_of_frame),
        .status        (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // parser model state
    phase_t       fr_phase = PH_HEADER;
    logic [3:0]   fr_count = '0;
    logic [23:0]  fr_length = '0;
    logic [7:0]   fr_type = '0;
    logic [7:0]   fr_flags = '0;
    logic [31:0]  fr_stream = '0;
    logic [7:0]   fr_pad = '0;
    logic [23:0]  data_remaining = '0;
    logic [23:0]  skip_remaining = '0;

    result_t      awaited_results[$];
    result_t      typed_results[int];
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           hold_request = 1'b0;
    int           hold_count = 0;
    int           bytes_sent = 0;
    int           n_headers = 0;
    int           n_payload = 0;
    int           errors = 0;
    int           idle_cycles = 0;

    logic [7:0] ok_types [4] = '{TYPE_HEADERS, TYPE_RST_STREAM, TYPE_SETTINGS,
                                 TYPE_WINDOW_UPDATE};
    logic [7:0] unimpl_types [5] = '{TYPE_PRIORITY, TYPE_PUSH_PROMISE, TYPE_PING,
                                     TYPE_GOAWAY, TYPE_CONTINUATION};

    // header, then pad err, then pad too large (length 2, pad 0xFF, one byte dropped)
    logic [7:0] directed_bytes [DIRECTED_LEN] = '{
        8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h02, 8'h00, 8'h08, 8'h80, 8'h00, 8'h00, 8'h01,
        8'hFF, 8'hA5
    };

    function automatic phase_t payload_phase();
        if (data_remaining != 0)
            return PH_DATA;
        else if (skip_remaining != 0)
            return PH_SKIP;
        return PH_HEADER;
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output result_t res);
        bit      emit;
        kind_t   k;
        logic    last;
        status_t st;
        emit = 1'b0;
        k    = KIND_HEADER;
        last = 1'b0;
        st   = ST_OK;
        case (fr_phase)
            PH_PADLEN:
            begin
                fr_pad = b;
                emit   = 1'b1;
                if ({16'd0, b} >= fr_length)
                begin
                    data_remaining = '0;
                    skip_remaining = fr_length - 24'd1;
                    last = 1'b1;
                    st   = ST_PAD_ERR;
                end
                else
                begin
                    data_remaining = fr_length - 24'd1 - {16'd0, b};
                    skip_remaining = {16'd0, b};
                    last = (data_remaining == 0);
                end
                fr_phase = payload_phase();
            end
            PH_DATA:
            begin
                data_remaining = data_remaining - 24'd1;
                last = (data_remaining == 0);
                if (last)
                    fr_phase = (skip_remaining != 0) ? PH_SKIP : PH_HEADER;
                emit = 1'b1;
                k    = KIND_DATA;
            end
            PH_SKIP:
            begin
                skip_remaining = skip_remaining - 24'd1;
                if (skip_remaining == 0)
                    fr_phase = PH_HEADER;
            end
            default:
            begin
                if (fr_count == 0)
                begin
                    fr_length = '0;
                    fr_stream = '0;
                end
                if (fr_count < 3)
                    fr_length = {fr_length[15:0], b};
                else if (fr_count == 3)
                    fr_type = b;
                else if (fr_count == 4)
                    fr_flags = b;
                else
                    fr_stream = {fr_stream[23:0], b};
                fr_count = fr_count + 4'd1;
                if (fr_count == 9)
                begin
                    fr_count       = '0;
                    fr_pad         = '0;
                    data_remaining = '0;
                    skip_remaining = '0;
                    emit = 1'b1;
                    last = 1'b1;
                    if (fr_type == TYPE_DATA && fr_flags[PADDED_BIT])
                    begin
                        if (fr_length == 0)
                            st = ST_PAD_ERR;
                        else
                        begin
                            emit     = 1'b0;
                            fr_phase = PH_PADLEN;
                        end
                    end
                    else if (fr_type == TYPE_DATA)
                    begin
                        data_remaining = fr_length;
                        last     = (fr_length == 0);
                        fr_phase = payload_phase();
                    end
                    else
                    begin
                        if (fr_type == TYPE_PRIORITY || fr_type == TYPE_PUSH_PROMISE ||
                            fr_type == TYPE_PING || fr_type == TYPE_GOAWAY ||
                            fr_type == TYPE_CONTINUATION)
                            st = ST_UNIMPL;
                        else if (fr_type > TYPE_CONTINUATION)
                            st = ST_INVALID;
                        skip_remaining = fr_length;
                        fr_phase = payload_phase();
                    end
                end
            end
        endcase
        res.kind          = k;
        res.frame_length  = fr_length;
        res.frame_type    = fr_type;
        res.frame_flags   = fr_flags;
        res.reserved_bit  = fr_stream[31];
        res.stream_id     = fr_stream[30:0];
        res.pad_length    = fr_pad;
        res.payload_byte  = (k == KIND_DATA) ? b : 8'd0;
        res.last_of_frame = last;
        res.status        = st;
        return emit;
    endfunction

    // entered and left at a falling edge; valid stays high on return
    task automatic offer_byte(input logic [7:0] b, input bit typed, input result_t typed_res);
        result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
        if (deframe_byte(b, predicted))
            awaited_results.push_back(typed ? typed_res : predicted);
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [7:0] flags,
                              input logic [23:0] len, input logic [31:0] stream,
                              input logic [7:0] pad, input bit with_payload);
        logic [71:0] hdr;
        hdr = {len, ftype, flags, stream};
        for (int i = 0; i < 9; i++)
            offer_byte(hdr[71 - 8*i -: 8], 1'b0, '0);
        if (with_payload)
            for (int i = 0; i < len; i++)
                offer_byte((i == 0 && ftype == TYPE_DATA && flags[PADDED_BIT]) ?
                           pad : 8'($urandom), 1'b0, '0);
    endtask

    task automatic send_random_frame();
        logic [7:0]  ftype;
        logic [7:0]  flags;
        logic [7:0]  pad;
        logic [23:0] len;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            ftype = TYPE_DATA;
        else if (r < 70)
            ftype = ok_types[$urandom_range(0, 3)];
        else if (r < 85)
            ftype = unimpl_types[$urandom_range(0, 4)];
        else
            ftype = 8'($urandom_range(10, 255));
        flags = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 3)
            len = 24'($urandom_range(256, 300));
        else if (r < 12)
            len = '0;
        else
            len = 24'($urandom_range(1, 24));
        if (len <= 255 && $urandom_range(0, 99) < 20)
            pad = 8'($urandom_range(len, 255));
        else if (len != 0)
            pad = 8'($urandom_range(0, (len > 256) ? 255 : len - 1));
        else
            pad = '0;
        send_frame(ftype, flags, len, $urandom(), pad, 1'b1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (awaited_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_request)
        begin
            out_stall <= 1'b1;
            hold_count++;
            if (hold_count == HOLD_CYCLES)
            begin
                hold_count   = 0;
                hold_request = 1'b0;
            end
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected item, expected none, actual kind=%0d len=0x%0h",
                         $time, kind, frame_length);
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("kind", want.kind, kind);
                check_field("frame_length", want.frame_length, frame_length);
                check_field("frame_type", want.frame_type, frame_type);
                check_field("frame_flags", want.frame_flags, frame_flags);
                check_field("reserved_bit", want.reserved_bit, reserved_bit);
                check_field("stream_id", want.stream_id, stream_id);
                check_field("pad_length", want.pad_length, pad_length);
                check_field("payload_byte", want.payload_byte, payload_byte);
                check_field("last_of_frame", want.last_of_frame, last_of_frame);
                check_field("status", want.status, status);
                if (want.kind == KIND_DATA)
                    n_payload++;
                else
                    n_headers++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        typed_results[8]  = result_t'{KIND_HEADER, 24'd0, 8'hFF, 8'hFF, 1'b1,
                                      31'h7FFF_FFFF, 8'd0, 8'd0, 1'b1, ST_INVALID};
        typed_results[17] = result_t'{KIND_HEADER, 24'd0, TYPE_DATA, 8'h08, 1'b0,
                                      31'd0, 8'd0, 8'd0, 1'b1, ST_PAD_ERR};
        typed_results[27] = result_t'{KIND_HEADER, 24'd2, TYPE_DATA, 8'h08, 1'b1,
                                      31'd1, 8'hFF, 8'd0, 1'b1, ST_PAD_ERR};

        send_idle_pct = 31;
        recv_idle_pct = 69;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_LEN; i++)
            offer_byte(directed_bytes[i], typed_results.exists(i),
                       typed_results.exists(i) ? typed_results[i] : result_t'('0));
        while (bytes_sent < 270)
            send_random_frame();
        drain();

        send_idle_pct = 69;
        recv_idle_pct = 31;
        while (bytes_sent < 520)
            send_random_frame();
        drain();

        // back-to-back, with the output held long enough to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        send_frame(TYPE_DATA, 8'h00, 24'd80, $urandom(), 8'd0, 1'b1);
        while (bytes_sent < 740)
            send_random_frame();
        // maximum length header; its payload never follows
        send_frame(TYPE_HEADERS, 8'($urandom), 24'hFF_FFFF, $urandom(), 8'd0, 1'b0);
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (awaited_results.size() != 0)
            errors++;
        $display("Sent %0d stream bytes: hand-built error frames, two idle mixes, a",
                 bytes_sent);
        $display("long output hold and a max-length header; %0d reports, %0d data bytes, %0d errors",
                 n_headers, n_payload, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
